>>> rtl/isu_pkg.sv
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types, constants and state tables of the idle state selector.
// ----------------------------------------------------------------------------
package isu_pkg;

  localparam int IDX_W        = 3;
  localparam int LVL_W        = 2;
  localparam int LIMIT_W      = 20;
  localparam int LAT_W        = 16;
  localparam int NUM_STATES_D = 8;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  // power levels
  localparam logic [LVL_W-1:0] LVL_OFF   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_RET   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_INACT = 2'd2;
  localparam logic [LVL_W-1:0] LVL_ON    = 2'd3;

  // register indexes
  localparam logic [1:0] REG_OFF_MODE   = 2'd0;
  localparam logic [1:0] REG_CORE_BLOCK = 2'd1;
  localparam logic [1:0] REG_FORCED     = 2'd2;
  localparam logic [1:0] REG_VALID_MASK = 2'd3;

  typedef struct packed {
    logic       off_mode_enable;
    logic       core_off_block;
    logic [3:0] forced_state;
    logic [7:0] valid_mask;
  } isu_cfg_t;

  typedef enum logic [1:0] {
    WM_USE,
    WM_LAT,
    WM_LVL
  } walk_mode_t;

  typedef struct packed {
    walk_mode_t         mode;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         mask;
    logic [LIMIT_W-1:0] limit;
    logic [LVL_W-1:0]   core_min;
    logic [LVL_W-1:0]   mpu_min;
  } walk_req_t;

  typedef struct packed {
    logic             stop;
    logic [IDX_W-1:0] idx_dec;
  } walk_rsp_t;

  // sleep + wake latency in microseconds
  function automatic logic [LAT_W-1:0] exit_lat(input logic [IDX_W-1:0] idx);
    logic [LAT_W-1:0] r;
    case (idx)
      3'd0:    r = 16'd4;
      3'd1:    r = 16'd20;
      3'd2:    r = 16'd100;
      3'd3:    r = 16'd3300;
      3'd4:    r = 16'd10000;
      3'd5:    r = 16'd11500;
      3'd6:    r = 16'd40000;
      3'd7:    r = 16'd40000;
      default: r = 16'd40000;
    endcase
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] mpu_lvl(input logic [IDX_W-1:0] idx);
    logic [LVL_W-1:0] r;
    case (idx)
      3'd0:    r = LVL_ON;
      3'd1:    r = LVL_INACT;
      3'd2:    r = LVL_RET;
      3'd4:    r = LVL_RET;
      default: r = LVL_OFF;
    endcase
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] core_lvl(input logic [IDX_W-1:0] idx);
    logic [LVL_W-1:0] r;
    case (idx)
      3'd0:    r = LVL_ON;
      3'd1:    r = LVL_INACT;
      3'd2:    r = LVL_INACT;
      3'd3:    r = LVL_INACT;
      3'd4:    r = LVL_RET;
      3'd5:    r = LVL_RET;
      default: r = LVL_OFF;
    endcase
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] safe_per(input logic [LVL_W-1:0] lvl);
    return (lvl == LVL_OFF) ? LVL_RET : lvl;
  endfunction

endpackage

>>> rtl/isu_regs.sv
// ----------------------------------------------------------------------------
// isu_regs
// APB register file: off mode, core off block, forced state, valid mask.
// ----------------------------------------------------------------------------
module isu_regs
  import isu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output isu_cfg_t           cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_mode_enable <= 1'b0;
      cfg.core_off_block  <= 1'b0;
      cfg.forced_state    <= 4'd0;
      cfg.valid_mask      <= 8'hff;
    end else if (wr_en) begin
      case (reg_sel)
        REG_OFF_MODE:   cfg.off_mode_enable <= pwdata[0];
        REG_CORE_BLOCK: cfg.core_off_block  <= pwdata[0];
        REG_FORCED:     cfg.forced_state    <= pwdata[3:0];
        REG_VALID_MASK: cfg.valid_mask      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OFF_MODE:   prdata = {31'd0, cfg.off_mode_enable};
      REG_CORE_BLOCK: prdata = {31'd0, cfg.core_off_block};
      REG_FORCED:     prdata = {28'd0, cfg.forced_state};
      REG_VALID_MASK: prdata = {24'd0, cfg.valid_mask};
      default:        prdata = '0;
    endcase
  end

endmodule

>>> rtl/isu_walk.sv
// ----------------------------------------------------------------------------
// isu_walk
// Shared step unit: checks one state index per cycle against the current
// walk condition and offers the next lower index.
// ----------------------------------------------------------------------------
module isu_walk
  import isu_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_D
) (
  input  walk_req_t req,
  output walk_rsp_t rsp
);

  localparam logic [IDX_W:0] NUM_W = (IDX_W + 1)'(NUM_STATES);

  logic [7:0] mask1;
  logic       usable;
  logic       cond;

  assign mask1  = req.mask | 8'd1;
  assign usable = ({1'b0, req.idx} < NUM_W) && mask1[req.idx];

  always_comb begin
    case (req.mode)
      WM_USE:  cond = 1'b1;
      WM_LAT:  cond = {{(LIMIT_W - LAT_W){1'b0}}, exit_lat(req.idx)} <= req.limit;
      WM_LVL:  cond = (core_lvl(req.idx) >= req.core_min) &&
                      (mpu_lvl(req.idx) >= req.mpu_min);
      default: cond = 1'b1;
    endcase
  end

  assign rsp.stop    = (req.idx == '0) || (usable && cond);
  assign rsp.idx_dec = req.idx - 1'b1;

endmodule

>>> rtl/isu_seq.sv
// ----------------------------------------------------------------------------
// isu_seq
// Sequencer: runs the usable, latency and level walks on the step unit,
// derives the domain targets and registers the result.
// ----------------------------------------------------------------------------
module isu_seq
  import isu_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_D
) (
  input  logic               clk,
  input  logic               rst,
  input  isu_cfg_t           cfg,
  input  logic               start,
  output logic               busy,
  input  logic [IDX_W-1:0]   requested_state,
  input  logic               bus_busy,
  input  logic [LIMIT_W-1:0] latency_limit,
  input  logic               core_can_idle,
  input  logic               per_can_idle,
  input  logic [LVL_W-1:0]   per_next_level,
  input  logic [LVL_W-1:0]   cam_level,
  input  logic [LVL_W-1:0]   dss_level,
  input  logic [LVL_W-1:0]   iva_level,
  input  logic [LVL_W-1:0]   gfx_level,
  input  logic [LVL_W-1:0]   usb_level,
  output walk_req_t          wreq,
  input  walk_rsp_t          wrsp,
  output logic               done,
  output logic [IDX_W-1:0]   chosen_state,
  output logic [LVL_W-1:0]   per_target_level,
  output logic               per_override,
  output logic               fell_to_safe
);

  localparam logic [IDX_W-1:0] LAST  = IDX_W'(NUM_STATES - 1);
  localparam logic [IDX_W:0]   NUM_W = (IDX_W + 1)'(NUM_STATES);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t             state;
  walk_mode_t         mode;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   fidx;
  logic               forced;
  logic [LVL_W-1:0]   core_t;
  logic [LVL_W-1:0]   mpu_t;
  logic [LVL_W-1:0]   ps;
  logic               bus_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               core_idle_r;
  logic               per_idle_r;
  logic [LVL_W-1:0]   per_next_r;
  logic [LVL_W-1:0]   cam_r;
  logic [LVL_W-1:0]   dss_r;
  logic [LVL_W-1:0]   iva_r;
  logic [LVL_W-1:0]   gfx_r;
  logic [LVL_W-1:0]   usb_r;

  logic [IDX_W-1:0] forced_idx;
  logic [7:0]       mask1;
  logic             forced_ok;
  logic [LVL_W-1:0] d_core;
  logic [LVL_W-1:0] d_mpu;
  logic [LVL_W-1:0] d_ps;
  logic             fire;
  logic [IDX_W-1:0] res_state;
  logic [LVL_W-1:0] res_target;
  logic             res_fell;

  assign busy = (state != S_IDLE);

  assign wreq.mode     = mode;
  assign wreq.idx      = idx;
  assign wreq.mask     = cfg.valid_mask;
  assign wreq.limit    = limit_r;
  assign wreq.core_min = core_t;
  assign wreq.mpu_min  = mpu_t;

  assign forced_idx = IDX_W'(cfg.forced_state - 4'd1);
  assign mask1      = cfg.valid_mask | 8'd1;
  assign forced_ok  = (cfg.forced_state != 4'd0) && (cfg.forced_state <= 4'd8) &&
                      ({1'b0, forced_idx} < NUM_W) && mask1[forced_idx];

  // domain targets for the state the latency walk stopped at
  always_comb begin
    d_core = core_lvl(idx);
    d_mpu  = mpu_lvl(idx);
    if (!cfg.off_mode_enable) begin
      if (d_mpu < LVL_RET) d_mpu = LVL_RET;
      if (d_core < LVL_RET) d_core = LVL_RET;
    end
    if (!core_idle_r) d_core = LVL_INACT;
    if (dss_r == LVL_ON) d_core = LVL_INACT;
    if (d_core == LVL_OFF && cfg.core_off_block) d_core = LVL_RET;
    d_ps = per_next_r;
    if (d_ps == LVL_OFF && (!per_idle_r || d_core != LVL_OFF)) d_ps = LVL_RET;
    if (d_core == LVL_OFF && (cam_r != LVL_OFF || dss_r != LVL_OFF ||
        iva_r != LVL_OFF || d_ps != LVL_OFF || gfx_r != LVL_OFF ||
        usb_r != LVL_OFF)) begin
      d_core = LVL_RET;
    end
  end

  // end of the item: result selection
  always_comb begin
    fire       = 1'b0;
    res_state  = '0;
    res_target = safe_per(per_next_r);
    res_fell   = 1'b0;
    if (state == S_WALK && wrsp.stop) begin
      case (mode)
        WM_USE: begin
          if (idx == '0) begin
            fire = 1'b1;
          end else if (bus_r) begin
            fire     = 1'b1;
            res_fell = 1'b1;
          end
        end
        WM_LAT: begin
          if (cam_r == LVL_ON) begin
            fire     = 1'b1;
            res_fell = 1'b1;
          end
        end
        WM_LVL: begin
          fire = 1'b1;
          if (forced && idx != fidx) begin
            res_fell = 1'b1;
          end else begin
            res_state  = idx;
            res_target = (idx == '0) ? safe_per(ps) : ps;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      mode  <= WM_USE;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state       <= S_WALK;
            mode        <= WM_USE;
            forced      <= 1'b0;
            idx         <= (requested_state > LAST) ? LAST : requested_state;
            bus_r       <= bus_busy;
            limit_r     <= latency_limit;
            core_idle_r <= core_can_idle;
            per_idle_r  <= per_can_idle;
            per_next_r  <= per_next_level;
            cam_r       <= cam_level;
            dss_r       <= dss_level;
            iva_r       <= iva_level;
            gfx_r       <= gfx_level;
            usb_r       <= usb_level;
          end
        end
        S_WALK: begin
          if (fire) begin
            state            <= S_IDLE;
            done             <= 1'b1;
            chosen_state     <= res_state;
            per_target_level <= res_target;
            per_override     <= (res_target != per_next_r);
            fell_to_safe     <= res_fell;
          end else if (!wrsp.stop) begin
            idx <= wrsp.idx_dec;
          end else begin
            case (mode)
              WM_USE: begin
                mode <= WM_LAT;
                if (forced_ok) begin
                  forced <= 1'b1;
                  fidx   <= forced_idx;
                  idx    <= forced_idx;
                end
              end
              WM_LAT: begin
                mode   <= WM_LVL;
                core_t <= d_core;
                mpu_t  <= d_mpu;
                ps     <= d_ps;
              end
              default: mode <= WM_USE;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result strobe lasts a single cycle: every item walks at least once
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_fell_safe: assert property (@(posedge clk) disable iff (rst)
    (done && fell_to_safe) |-> (chosen_state == '0))
    else $error("fallback without safe state");

  a_safe_per: assert property (@(posedge clk) disable iff (rst)
    (done && chosen_state == '0) |-> (per_target_level != LVL_OFF))
    else $error("safe state with per off");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (idx <= LAST))
    else $error("walk index beyond last state");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE)) else $error("result while still walking");

endmodule

>>> rtl/idle_state_selector_unit.sv
// ----------------------------------------------------------------------------
// idle_state_selector_unit
// Picks the idle state and the peripheral domain level for one request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The sequencer then
// walks the state table one index per clock on a single step unit, in three
// passes: down to a usable state, down while the exit latency exceeds the
// limit, and down until the state's mpu and core levels meet the targets.
// The level pass goes on from where the latency pass stopped; the longest
// walk comes with a forced state above the requested one. A busy bus or a
// camera domain at ON ends the walk early in the safe state. done strobes the
// result for one cycle right after the walk; busy stays high until then.
// The result must be taken in that cycle. The user is to write registers
// over the APB port only while busy is low; the block does not enforce it.
module idle_state_selector_unit
  import isu_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_D
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [IDX_W-1:0]   requested_state,
  input  logic               bus_busy,
  input  logic [LIMIT_W-1:0] latency_limit,
  input  logic               core_can_idle,
  input  logic               per_can_idle,
  input  logic [LVL_W-1:0]   per_next_level,
  input  logic [LVL_W-1:0]   cam_level,
  input  logic [LVL_W-1:0]   dss_level,
  input  logic [LVL_W-1:0]   iva_level,
  input  logic [LVL_W-1:0]   gfx_level,
  input  logic [LVL_W-1:0]   usb_level,
  output logic               done,
  output logic [IDX_W-1:0]   chosen_state,
  output logic [LVL_W-1:0]   per_target_level,
  output logic               per_override,
  output logic               fell_to_safe,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  isu_cfg_t  cfg;
  walk_req_t wreq;
  walk_rsp_t wrsp;

  isu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  isu_walk #(
    .NUM_STATES (NUM_STATES)
  ) u_walk (
    .req (wreq),
    .rsp (wrsp)
  );

  isu_seq #(
    .NUM_STATES (NUM_STATES)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .start            (start),
    .busy             (busy),
    .requested_state  (requested_state),
    .bus_busy         (bus_busy),
    .latency_limit    (latency_limit),
    .core_can_idle    (core_can_idle),
    .per_can_idle     (per_can_idle),
    .per_next_level   (per_next_level),
    .cam_level        (cam_level),
    .dss_level        (dss_level),
    .iva_level        (iva_level),
    .gfx_level        (gfx_level),
    .usb_level        (usb_level),
    .wreq             (wreq),
    .wrsp             (wrsp),
    .done             (done),
    .chosen_state     (chosen_state),
    .per_target_level (per_target_level),
    .per_override     (per_override),
    .fell_to_safe     (fell_to_safe)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the idle state selector. A driver feeds requests
// from a queue, a predictor works out the chosen state and PER level for each
// accepted item, and a monitor checks every done strobe against it. The run
// walks through directed corner cases and then random phases under several
// register settings and sender gap rates.
// ----------------------------------------------------------------------------
module tb;
  import isu_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   req_state;
    logic               bus_busy;
    logic [LIMIT_W-1:0] lat_limit;
    logic               core_idle;
    logic               per_idle;
    logic [LVL_W-1:0]   per_next;
    logic [LVL_W-1:0]   cam;
    logic [LVL_W-1:0]   dss;
    logic [LVL_W-1:0]   iva;
    logic [LVL_W-1:0]   gfx;
    logic [LVL_W-1:0]   usb;
  } idle_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] state;
    logic [LVL_W-1:0] per_level;
    logic             per_ovr;
    logic             safe;
  } idle_pick_t;

  // sleep + wake latency, mpu and core level of each idle state
  localparam int EXIT_US [0:7] = '{4, 20, 100, 3300, 10000, 11500, 40000, 40000};
  localparam logic [LVL_W-1:0] MPU_OF [0:7] = '{LVL_ON, LVL_INACT, LVL_RET, LVL_OFF,
                                                 LVL_RET, LVL_OFF, LVL_OFF, LVL_OFF};
  localparam logic [LVL_W-1:0] CORE_OF [0:7] = '{LVL_ON, LVL_INACT, LVL_INACT, LVL_INACT,
                                                  LVL_RET, LVL_RET, LVL_OFF, LVL_OFF};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  idle_req_t drv_item = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;

  logic busy, done, per_override, fell_to_safe, pready;
  logic [IDX_W-1:0] chosen_state;
  logic [LVL_W-1:0] per_target_level;
  logic [PDATA_W-1:0] prdata;

  // register copy used by the predictor
  logic       cfg_off_mode = 1'b0;
  logic       cfg_core_block = 1'b0;
  logic [3:0] cfg_forced = 4'd0;
  logic [7:0] cfg_mask = 8'hFF;

  idle_req_t  pending_items[$];
  idle_pick_t expected_picks[$];
  logic taken = 1'b0;
  int gap_pct = 0;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_safe = 0;
  int n_phases = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  idle_state_selector_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .requested_state  (drv_item.req_state),
    .bus_busy         (drv_item.bus_busy),
    .latency_limit    (drv_item.lat_limit),
    .core_can_idle    (drv_item.core_idle),
    .per_can_idle     (drv_item.per_idle),
    .per_next_level   (drv_item.per_next),
    .cam_level        (drv_item.cam),
    .dss_level        (drv_item.dss),
    .iva_level        (drv_item.iva),
    .gfx_level        (drv_item.gfx),
    .usb_level        (drv_item.usb),
    .done             (done),
    .chosen_state     (chosen_state),
    .per_target_level (per_target_level),
    .per_override     (per_override),
    .fell_to_safe     (fell_to_safe),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  function automatic logic state_ok(input int i);
    if (i < 0 || i >= 8) return 1'b0;
    return 1'((cfg_mask | 8'h01) >> i);
  endfunction

  function automatic int next_lower(input int i);
    while (i > 0) begin
      i--;
      if (state_ok(i)) return i;
    end
    return 0;
  endfunction

  function automatic logic [LVL_W-1:0] ret_if_off(input logic [LVL_W-1:0] lvl);
    return (lvl == LVL_OFF) ? LVL_RET : lvl;
  endfunction

  function automatic idle_pick_t pick_idle_state(input idle_req_t it);
    int s;
    int req;
    int fidx;
    logic forced;
    logic [LVL_W-1:0] mpu_min, core_min, ps;
    idle_pick_t r;
    r = '0;
    ps = it.per_next;
    req = it.req_state;
    if (!state_ok(req)) req = next_lower(req);
    // a request for the safe state skips every rule
    if (req != 0) begin
      if (it.bus_busy) begin
        r.safe = 1'b1;
      end else begin
        s = req;
        forced = 1'b0;
        fidx = 0;
        if (cfg_forced >= 4'd1 && cfg_forced <= 4'd8 && state_ok(int'(cfg_forced) - 1)) begin
          forced = 1'b1;
          fidx = int'(cfg_forced) - 1;
          s = fidx;
        end
        while (s != 0 && EXIT_US[s] > int'(it.lat_limit)) s = next_lower(s);
        core_min = CORE_OF[s];
        mpu_min = MPU_OF[s];
        if (!cfg_off_mode) begin
          if (mpu_min < LVL_RET) mpu_min = LVL_RET;
          if (core_min < LVL_RET) core_min = LVL_RET;
        end
        if (!it.core_idle) core_min = LVL_INACT;
        if (it.cam == LVL_ON) begin
          r.safe = 1'b1;
        end else begin
          if (it.dss == LVL_ON) core_min = LVL_INACT;
          if (core_min == LVL_OFF && cfg_core_block) core_min = LVL_RET;
          if (ps == LVL_OFF && (!it.per_idle || core_min > LVL_OFF)) ps = LVL_RET;
          if (core_min == LVL_OFF && (it.cam != 0 || it.dss != 0 || it.iva != 0 ||
                                      ps != 0 || it.gfx != 0 || it.usb != 0))
            core_min = LVL_RET;
          while (s != 0 && (CORE_OF[s] < core_min || MPU_OF[s] < mpu_min))
            s = next_lower(s);
          if (forced && s != fidx) begin
            r.safe = 1'b1;
          end else begin
            r.state = IDX_W'(s);
            r.per_level = (s == 0) ? ret_if_off(ps) : ps;
          end
        end
      end
    end else begin
      r.per_level = ret_if_off(it.per_next);
    end
    if (r.safe) begin
      r.state = '0;
      r.per_level = ret_if_off(it.per_next);
    end
    r.per_ovr = (r.per_level != it.per_next);
    return r;
  endfunction

  // driver: holds an item on the ports until it is taken
  always @(negedge clk) begin : drv
    logic go;
    go = start && !taken;
    if (taken) void'(pending_items.pop_front());
    if (!go && !rst && pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
      drv_item <= pending_items[0];
      go = 1'b1;
    end
    start <= go;
  end

  // monitor: predicts on accept, checks on done
  always @(posedge clk) begin : mon
    idle_pick_t want;
    if (!rst) begin
      taken <= start && !busy;
      if (start && !busy) begin
        expected_picks.push_back(pick_idle_state(drv_item));
        n_items++;
      end
      if (done) begin
        n_results++;
        if (fell_to_safe) n_safe++;
        if (expected_picks.size() == 0) begin
          $error("result with no item pending: chosen_state %0d", chosen_state);
          errors++;
        end else begin
          want = expected_picks.pop_front();
          if (chosen_state !== want.state) begin
            $error("chosen_state: expected %0d, got %0d", want.state, chosen_state);
            errors++;
          end
          if (per_target_level !== want.per_level) begin
            $error("per_target_level: expected %0d, got %0d", want.per_level,
                   per_target_level);
            errors++;
          end
          if (per_override !== want.per_ovr) begin
            $error("per_override: expected %0d, got %0d", want.per_ovr, per_override);
            errors++;
          end
          if (fell_to_safe !== want.safe) begin
            $error("fell_to_safe: expected %0d, got %0d", want.safe, fell_to_safe);
            errors++;
          end
        end
      end
    end
  end

  function automatic idle_req_t quiet_item(input int req, input int limit);
    idle_req_t it;
    it = '0;
    it.req_state = IDX_W'(req);
    it.lat_limit = LIMIT_W'(limit);
    it.core_idle = 1'b1;
    it.per_idle = 1'b1;
    return it;
  endfunction

  function automatic idle_req_t random_item();
    idle_req_t it;
    int k;
    it.req_state = IDX_W'($urandom_range(0, 7));
    it.bus_busy = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 3))
      0: it.lat_limit = LIMIT_W'($urandom);
      1: begin
        k = EXIT_US[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
        it.lat_limit = LIMIT_W'(k);
      end
      2: it.lat_limit = LIMIT_W'($urandom_range(0, 200));
      default: it.lat_limit = ($urandom_range(0, 1) == 1) ? {LIMIT_W{1'b1}} :
                              LIMIT_W'($urandom_range(40000, 1048575));
    endcase
    it.core_idle = ($urandom_range(0, 4) != 0);
    it.per_idle = ($urandom_range(0, 4) != 0);
    it.per_next = LVL_W'($urandom_range(0, 3));
    // half the items keep the other domains off (a quarter of them turn one on) so deep core states are reachable
    if ($urandom_range(0, 1) == 0) begin
      it.cam = LVL_OFF;
      it.dss = LVL_OFF;
      it.iva = LVL_OFF;
      it.gfx = LVL_OFF;
      it.usb = LVL_OFF;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: it.cam = LVL_W'($urandom_range(1, 2));
          1: it.dss = LVL_W'($urandom_range(1, 3));
          2: it.iva = LVL_W'($urandom_range(1, 3));
          3: it.gfx = LVL_W'($urandom_range(1, 3));
          default: it.usb = LVL_W'($urandom_range(1, 3));
        endcase
      end
    end else begin
      it.cam = LVL_W'($urandom_range(0, 3));
      it.dss = LVL_W'($urandom_range(0, 3));
      it.iva = LVL_W'($urandom_range(0, 3));
      it.gfx = LVL_W'($urandom_range(0, 3));
      it.usb = LVL_W'($urandom_range(0, 3));
    end
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || expected_picks.size() != 0 || start || busy)
      @(negedge clk);
  endtask

  function automatic logic [PDATA_W-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_OFF_MODE:   return PDATA_W'(cfg_off_mode);
      REG_CORE_BLOCK: return PDATA_W'(cfg_core_block);
      REG_FORCED:     return PDATA_W'(cfg_forced);
      default:        return PDATA_W'(cfg_mask);
    endcase
  endfunction

  // write one register, then read it back
  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OFF_MODE:   cfg_off_mode = val[0];
      REG_CORE_BLOCK: cfg_core_block = val[0];
      REG_FORCED:     cfg_forced = val[3:0];
      default:        cfg_mask = val[7:0];
    endcase
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== reg_value(idx)) begin
      $error("prdata of register %0d: expected %0h, got %0h", idx, reg_value(idx), rd);
      errors++;
    end
  endtask

  task automatic set_config(input logic off, input logic blk, input logic [3:0] forced,
                            input logic [7:0] mask);
    drain();
    // random upper bits check that only the register width is kept
    write_reg(REG_OFF_MODE, ($urandom & ~32'h1) | PDATA_W'(off));
    write_reg(REG_CORE_BLOCK, ($urandom & ~32'h1) | PDATA_W'(blk));
    write_reg(REG_FORCED, ($urandom & ~32'hF) | PDATA_W'(forced));
    write_reg(REG_VALID_MASK, ($urandom & ~32'hFF) | PDATA_W'(mask));
  endtask

  initial begin : stim
    idle_req_t it;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset settings first
    it = quiet_item(0, 0);
    it.bus_busy = 1'b1;
    it.cam = LVL_ON;
    pending_items.push_back(it);
    pending_items.push_back(quiet_item(7, 20'hFFFFF));
    pending_items.push_back(quiet_item(7, 0));
    it = quiet_item(3, 20'hFFFFF);
    it.bus_busy = 1'b1;
    pending_items.push_back(it);
    it = quiet_item(5, 20'hFFFFF);
    it.cam = LVL_ON;
    pending_items.push_back(it);
    it = quiet_item(7, 20'hFFFFF);
    it.dss = LVL_ON;
    pending_items.push_back(it);
    it = quiet_item(6, 20'hFFFFF);
    it.core_idle = 1'b0;
    pending_items.push_back(it);
    it = quiet_item(4, 20'hFFFFF);
    it.per_idle = 1'b0;
    pending_items.push_back(it);
    pending_items.push_back('1);
    pending_items.push_back('0);

    // off mode allowed: core may reach off
    set_config(1'b1, 1'b0, 4'd0, 8'hFF);
    pending_items.push_back(quiet_item(7, 20'hFFFFF));
    it = quiet_item(7, 20'hFFFFF);
    it.iva = LVL_RET;
    pending_items.push_back(it);
    it = quiet_item(7, 20'hFFFFF);
    it.per_idle = 1'b0;
    pending_items.push_back(it);

    // core off blocked
    set_config(1'b1, 1'b1, 4'd0, 8'hFF);
    pending_items.push_back(quiet_item(7, 20'hFFFFF));

    // forced state that off mode clamping makes unreachable
    set_config(1'b0, 1'b0, 4'd4, 8'hFF);
    pending_items.push_back(quiet_item(1, 20'hFFFFF));
    pending_items.push_back(quiet_item(1, 10));
    set_config(1'b1, 1'b0, 4'd4, 8'hFF);
    pending_items.push_back(quiet_item(7, 20'hFFFFF));

    // forced state out of range, then masked: both act as none
    set_config(1'b1, 1'b0, 4'd15, 8'hFF);
    pending_items.push_back(quiet_item(7, 5000));
    set_config(1'b1, 1'b0, 4'd5, 8'hEF);
    pending_items.push_back(quiet_item(5, 20'hFFFFF));
    pending_items.push_back(quiet_item(4, 20'hFFFFF));

    // empty mask leaves only the safe state; forced safe state
    set_config(1'b0, 1'b0, 4'd1, 8'h00);
    pending_items.push_back(quiet_item(7, 20'hFFFFF));
    set_config(1'b1, 1'b0, 4'd1, 8'hFF);
    pending_items.push_back(quiet_item(5, 20'hFFFFF));

    // random phases
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_config(1'b0, 1'b0, 4'd0, 8'hFF);
        1: set_config(1'b1, 1'b0, 4'd0, 8'hFF);
        2: set_config(1'b1, 1'b1, 4'd0, 8'hFF);
        3: set_config(1'b1, 1'b0, 4'd8, 8'hFF);
        4: set_config(1'b0, 1'b1, 4'd0, 8'h01);
        default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd0,
                             ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
      endcase
      case (p % 4)
        1:       gap_pct = 58;
        3:       gap_pct = 19;
        default: gap_pct = 0;
      endcase
      n_phases++;
      for (int n = 0; n < 70; n++) pending_items.push_back(random_item());
    end

    drain();
    repeat (3 * NUM_STATES_D + 8) @(posedge clk);
    $display("covered %0d requests in %0d random phases plus directed cases", n_items,
             n_phases);
    $display("checked %0d results, %0d of them fell back to the safe state", n_results,
             n_safe);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout: %0d items still queued, %0d results outstanding",
             pending_items.size(), expected_picks.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
